// ===== rtl/vector_normalize_fixed_unit_defines.svh =====
// Assertion macros shared by the vector normalize RTL.
`ifndef VECTOR_NORMALIZE_FIXED_UNIT_DEFINES_SVH
`define VECTOR_NORMALIZE_FIXED_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define VNF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) \
    else $error("check failed");
`define VNF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define VNF_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define VNF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/vnf_pkg.sv =====
// Types and constants for the vector normalize unit.
package vnf_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = 16;
  localparam int DIM_W         = 3;
  localparam int NUM_LANES     = 4;
  localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;

  localparam int SQ_W  = 2 * IN_WIDTH;
  localparam int SUM_W = SQ_W + 2;
  localparam int Q_W   = OUT_FRAC_BITS + 1;
  localparam int T_W   = SUM_W + OUT_FRAC_BITS + 1;
  localparam int CMP_W = SUM_W + 2 * OUT_FRAC_BITS + 3;
  // search stages plus the load stage in each lane
  localparam int LANE_DEPTH = OUT_FRAC_BITS + 2;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] comp_x;
    logic signed [IN_WIDTH-1:0] comp_y;
    logic signed [IN_WIDTH-1:0] comp_z;
    logic signed [IN_WIDTH-1:0] comp_w;
  } in_data_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] unit_x;
    logic signed [OUT_WIDTH-1:0] unit_y;
    logic signed [OUT_WIDTH-1:0] unit_z;
    logic signed [OUT_WIDTH-1:0] unit_w;
    logic                        zero_length;
  } out_data_t;

endpackage

// ===== rtl/vnf_front.sv =====
// Front end: masks unused components, takes magnitudes and squares them.
module vnf_front (
  input  logic                                clk,
  input  logic                                en,
  input  logic [vnf_pkg::DIM_W-1:0]           dim,
  input  vnf_pkg::in_data_t                   in_data,
  output logic [vnf_pkg::SQ_W-1:0]            sq      [vnf_pkg::NUM_LANES],
  output logic [vnf_pkg::NUM_LANES-1:0]       neg
);

  logic [vnf_pkg::IN_WIDTH-1:0] comp   [vnf_pkg::NUM_LANES];
  logic [vnf_pkg::NUM_LANES-1:0] active;
  logic [vnf_pkg::IN_WIDTH-1:0] mag_r  [vnf_pkg::NUM_LANES];
  logic [vnf_pkg::NUM_LANES-1:0] neg_a_r;
  logic [vnf_pkg::SQ_W-1:0]     sq_r   [vnf_pkg::NUM_LANES];
  logic [vnf_pkg::NUM_LANES-1:0] neg_b_r;

  always_comb begin
    comp[0] = in_data.comp_x;
    comp[1] = in_data.comp_y;
    comp[2] = in_data.comp_z;
    comp[3] = in_data.comp_w;
    // dimension below two acts as two, above four as four
    active[0] = 1'b1;
    active[1] = 1'b1;
    active[2] = (dim >= vnf_pkg::DIM_W'(3));
    active[3] = (dim >= vnf_pkg::DIM_W'(4));
  end

  for (genvar i = 0; i < vnf_pkg::NUM_LANES; i++) begin : g_lane
    logic sgn;
    assign sgn = active[i] & comp[i][vnf_pkg::IN_WIDTH-1];

    always_ff @(posedge clk) begin
      if (en) begin
        neg_a_r[i] <= sgn;
        if (!active[i])
          mag_r[i] <= '0;
        else if (sgn)
          mag_r[i] <= (~comp[i]) + vnf_pkg::IN_WIDTH'(1);
        else
          mag_r[i] <= comp[i];
        sq_r[i]    <= vnf_pkg::SQ_W'(mag_r[i]) * vnf_pkg::SQ_W'(mag_r[i]);
        neg_b_r[i] <= neg_a_r[i];
      end
    end

    assign sq[i] = sq_r[i];
  end

  assign neg = neg_b_r;

endmodule

// ===== rtl/vnf_lane.sv =====
// One lane: bit-per-stage search for the truncated quotient a*2^F/sqrt(S).
`include "vector_normalize_fixed_unit_defines.svh"
module vnf_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          last_vld,
  input  logic [vnf_pkg::SQ_W-1:0]      sq,
  input  logic [vnf_pkg::SUM_W-1:0]     sum,
  output logic [vnf_pkg::Q_W-1:0]       q
);

  localparam int F = vnf_pkg::OUT_FRAC_BITS;

  // remainder a^2*4^F - q^2*S, running q*S, partial q, sum of squares
  logic [vnf_pkg::CMP_W-1:0] r_r [F+2];
  logic [vnf_pkg::T_W-1:0]   t_r [F+2];
  logic [vnf_pkg::Q_W-1:0]   q_r [F+2];
  logic [vnf_pkg::SUM_W-1:0] s_r [F+2];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= vnf_pkg::CMP_W'(sq) << (2 * F);
      t_r[0] <= '0;
      q_r[0] <= '0;
      s_r[0] <= sum;
    end
  end

  for (genvar k = 1; k <= F + 1; k++) begin : g_stage
    localparam int B = F + 1 - k;
    logic [vnf_pkg::CMP_W-1:0] tst;
    logic                      take;

    // (q + 2^B)^2 S - q^2 S = 2^(B+1) qS + 4^B S
    assign tst  = (vnf_pkg::CMP_W'(t_r[k-1]) << (B + 1))
                + (vnf_pkg::CMP_W'(s_r[k-1]) << (2 * B));
    assign take = (tst <= r_r[k-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= s_r[k-1];
        if (take) begin
          r_r[k] <= r_r[k-1] - tst;
          t_r[k] <= t_r[k-1] + (vnf_pkg::T_W'(s_r[k-1]) << B);
          q_r[k] <= q_r[k-1] | (vnf_pkg::Q_W'(1) << B);
        end else begin
          r_r[k] <= r_r[k-1];
          t_r[k] <= t_r[k-1];
          q_r[k] <= q_r[k-1];
        end
      end
    end
  end

  assign q = q_r[F+1];

  `VNF_ASSERT_NOW(a_q_le_one, clk, rst_n, last_vld && (s_r[F+1] != '0), q_r[F+1] <= (vnf_pkg::Q_W'(1) << F))
  `VNF_ASSERT_NOW(a_rem_lt_bound, clk, rst_n, last_vld && (s_r[F+1] != '0) && (q_r[F+1] != (vnf_pkg::Q_W'(1) << F)), r_r[F+1] < ((vnf_pkg::CMP_W'(t_r[F+1]) << 1) + vnf_pkg::CMP_W'(s_r[F+1])))
  `VNF_ASSERT_NOW(a_zero_sum_q, clk, rst_n, last_vld && (s_r[F+1] != '0) && (r_r[F+1] == '0) && (t_r[F+1] == '0), q_r[F+1] == '0)

endmodule

// ===== rtl/vector_normalize_fixed_unit.sv =====
// Top level of the vector normalize unit: lanes, merge and output register.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one vector of four signed
//   Q7.8 components. A transfer happens on a rising edge with in_valid high
//   and in_stall low. Output channel out_valid/out_stall/out_data carries the
//   unit vector in Q1.14 plus a zero_length flag, one result per input.
//   cfg_we/cfg_wdata write the dimension (2, 3 or 4; 0 and 1 act as 2, 5 to
//   7 as 4); unused components read as zero. Write it only while idle.
// Pipeline: 2 front stages, OUT_FRAC_BITS+2 lane stages and the output
//   register, 19 register stages at the default widths.
// Throughput: one vector per cycle while not stalled. Four lanes each resolve
//   one quotient bit per stage with one wide add and compare; a merge stage
//   applies signs and the zero-length flag.
// Stall: while out_valid is high and out_stall is high, the whole pipeline
//   holds and in_stall is raised; otherwise it advances every cycle.
// Reset: synchronous active-low rst_n empties the pipeline and sets the
//   dimension to 3.
`include "vector_normalize_fixed_unit_defines.svh"
module vector_normalize_fixed_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vnf_pkg::in_data_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vnf_pkg::out_data_t            out_data,
  input  logic                          cfg_we,
  input  logic [vnf_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int LD = vnf_pkg::LANE_DEPTH;

  logic                              en;
  logic [vnf_pkg::DIM_W-1:0]         dim_r;
  logic [1:0]                        vfront_r;
  logic [LD-1:0]                     vlane_r;
  logic [LD-1:0]                     zero_r;
  logic [vnf_pkg::NUM_LANES-1:0]     neg_r [LD];
  logic [vnf_pkg::SQ_W-1:0]          sq [vnf_pkg::NUM_LANES];
  logic [vnf_pkg::NUM_LANES-1:0]     neg;
  logic [vnf_pkg::SUM_W-1:0]         sum;
  logic [vnf_pkg::Q_W-1:0]           q [vnf_pkg::NUM_LANES];
  logic [vnf_pkg::OUT_WIDTH-1:0]     unit [vnf_pkg::NUM_LANES];
  logic                              out_valid_r;
  vnf_pkg::out_data_t                out_data_r;

  // hold everything while a finished result waits
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n)
      dim_r <= vnf_pkg::DIM_RESET;
    else if (cfg_we)
      dim_r <= cfg_wdata;
  end

  vnf_front u_front (
    .clk     (clk),
    .en      (en),
    .dim     (dim_r),
    .in_data (in_data),
    .sq      (sq),
    .neg     (neg)
  );

  assign sum = vnf_pkg::SUM_W'(sq[0]) + vnf_pkg::SUM_W'(sq[1])
             + vnf_pkg::SUM_W'(sq[2]) + vnf_pkg::SUM_W'(sq[3]);

  for (genvar i = 0; i < vnf_pkg::NUM_LANES; i++) begin : g_lane
    vnf_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .last_vld (vlane_r[LD-1]),
      .sq       (sq[i]),
      .sum      (sum),
      .q        (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vfront_r    <= '0;
      vlane_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vfront_r    <= {vfront_r[0], in_valid};
      vlane_r     <= {vlane_r[LD-2:0], vfront_r[1]};
      out_valid_r <= vlane_r[LD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (sum == '0);
      neg_r[0]  <= neg;
      for (int k = 1; k < LD; k++) begin
        zero_r[k] <= zero_r[k-1];
        neg_r[k]  <= neg_r[k-1];
      end
    end
  end

  // merge: apply sign, drop everything for a zero vector
  always_comb begin
    for (int i = 0; i < vnf_pkg::NUM_LANES; i++) begin
      if (zero_r[LD-1])
        unit[i] = '0;
      else if (neg_r[LD-1][i])
        unit[i] = vnf_pkg::OUT_WIDTH'(0) - vnf_pkg::OUT_WIDTH'(q[i]);
      else
        unit[i] = vnf_pkg::OUT_WIDTH'(q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.unit_x      <= unit[0];
      out_data_r.unit_y      <= unit[1];
      out_data_r.unit_z      <= unit[2];
      out_data_r.unit_w      <= unit[3];
      out_data_r.zero_length <= zero_r[LD-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VNF_ASSERT_NOW(a_zero_outputs, clk, rst_n, out_valid_r && out_data_r.zero_length, (out_data_r.unit_x == '0) && (out_data_r.unit_y == '0) && (out_data_r.unit_z == '0) && (out_data_r.unit_w == '0))
  `VNF_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !out_valid_r, !in_stall)
  `VNF_ASSERT_NXT(a_lane_to_out, clk, rst_n, en && vlane_r[LD-1], out_valid_r)

endmodule

// ===== tb/sv/vnf_checker.sv =====
// Checker for the vector normalize unit: predicts each unit vector and compares transfers.
`timescale 1ns / 100ps
module vnf_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  vnf_pkg::in_data_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  vnf_pkg::out_data_t        out_data,
  input  logic                      cfg_we,
  input  logic [vnf_pkg::DIM_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending_count
);

  logic [vnf_pkg::DIM_W-1:0] dim_reg;
  vnf_pkg::out_data_t        unit_fifo[$];

  // Largest q in 0..2^14 with q*q*sum <= a*a*4^14.
  function automatic longint unsigned unit_quotient(longint unsigned a, longint unsigned sum);
    longint unsigned bound, lo, hi, mid;
    bound = ((a * a) << (2 * vnf_pkg::OUT_FRAC_BITS)) / sum;
    lo = 0;
    hi = 64'd1 << vnf_pkg::OUT_FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic vnf_pkg::out_data_t normalize_vector(vnf_pkg::in_data_t v,
                                                          logic [vnf_pkg::DIM_W-1:0] dim);
    int unsigned                   used;
    logic signed [15:0]            comp[4];
    longint                        mag[4];
    longint unsigned               sum, q;
    logic [vnf_pkg::OUT_WIDTH-1:0] res[4];
    vnf_pkg::out_data_t            o;
    used = (dim < 2) ? 2 : (dim > 4) ? 4 : dim;
    comp[0] = v.comp_x;
    comp[1] = v.comp_y;
    comp[2] = v.comp_z;
    comp[3] = v.comp_w;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (i < used) ? longint'(comp[i]) : 0;
      if (mag[i] < 0) mag[i] = -mag[i];
      sum += longint'(mag[i]) * longint'(mag[i]);
    end
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (sum != 0 && mag[i] != 0) q = unit_quotient(mag[i], sum);
      res[i] = (i < used && comp[i] < 0) ? -q[vnf_pkg::OUT_WIDTH-1:0]
                                         : q[vnf_pkg::OUT_WIDTH-1:0];
    end
    o.unit_x = res[0];
    o.unit_y = res[1];
    o.unit_z = res[2];
    o.unit_w = res[3];
    o.zero_length = (sum == 0);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
  end

  assign pending_count = unit_fifo.size();

  always @(posedge clk) begin
    vnf_pkg::out_data_t want;
    if (!rst_n) begin
      dim_reg <= vnf_pkg::DIM_RESET;
      unit_fifo.delete();
    end else begin
      if (cfg_we) dim_reg <= cfg_wdata;
      if (in_valid && !in_stall) unit_fifo.push_back(normalize_vector(in_data, dim_reg));
      if (out_valid && !out_stall) begin
        if (unit_fifo.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = unit_fifo.pop_front();
          if (out_data.unit_x !== want.unit_x)
            report_mismatch("unit_x", out_data.unit_x, want.unit_x);
          if (out_data.unit_y !== want.unit_y)
            report_mismatch("unit_y", out_data.unit_y, want.unit_y);
          if (out_data.unit_z !== want.unit_z)
            report_mismatch("unit_z", out_data.unit_z, want.unit_z);
          if (out_data.unit_w !== want.unit_w)
            report_mismatch("unit_w", out_data.unit_w, want.unit_w);
          if (out_data.zero_length !== want.zero_length)
            report_mismatch("zero_length", out_data.zero_length, want.zero_length);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the vector normalize unit: clock, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 500000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  vnf_pkg::in_data_t         in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  vnf_pkg::out_data_t        out_data;
  logic                      cfg_we = 1'b0;
  logic [vnf_pkg::DIM_W-1:0] cfg_wdata = '0;
  logic                      steady = 1'b0;
  int                        fail_count, pending_count;
  int                        cycle_count = 0;
  int                        stall_left = 0;

  always #5 clk = ~clk;

  vector_normalize_fixed_unit dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_wdata
  );

  vnf_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_wdata,
    .fail_count, .pending_count
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 31)) - 16'd16;
      4: return $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic vnf_pkg::in_data_t pick_vector();
    vnf_pkg::in_data_t v;
    int r;
    r = $urandom_range(0, 9);
    v = {pick_comp(), pick_comp(), pick_comp(), pick_comp()};
    if (r == 0) begin
      v = '0;
    end else if (r == 1) begin
      // one axis only, the saturating case
      v = '0;
      case ($urandom_range(0, 3))
        0: v.comp_x = pick_comp();
        1: v.comp_y = pick_comp();
        2: v.comp_z = pick_comp();
        default: v.comp_w = pick_comp();
      endcase
    end else if (r == 2) begin
      v = {16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
    end
    return v;
  endfunction

  // Receiver side: random stall stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall <= (stall_left != 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_vector(vnf_pkg::in_data_t v);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every result is back, then let the pipe settle.
  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dimension(logic [vnf_pkg::DIM_W-1:0] d);
    drain_all();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_vectors(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 199) == 0) drain_all();
      send_vector(pick_vector());
    end
  endtask

  logic [vnf_pkg::DIM_W-1:0] dim_plan[11] = '{3'd2, 3'd4, 3'd0, 3'd1, 3'd5, 3'd6, 3'd7,
                                              3'd4, 3'd2, 3'd3, 3'd4};

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed vectors under the reset dimension
    send_vector('0);
    send_vector({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_vector({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_vector({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    send_vector({16'h8000, 16'h0000, 16'h0000, 16'h7fff});
    send_vector({16'h0000, 16'h7fff, 16'h0000, 16'h0000});
    send_vector({16'h0000, 16'h0000, 16'h8000, 16'h0000});
    send_vector({16'h0000, 16'h0000, 16'h0000, 16'h1234});
    send_vector({16'h0001, 16'h0000, 16'h0000, 16'h0000});
    send_vector({16'hffff, 16'hffff, 16'h0000, 16'h0000});
    send_vector({16'h0001, 16'h7fff, 16'h0000, 16'h0000});
    send_vector({16'h0300, 16'h0400, 16'h0000, 16'h0000});
    send_vector({16'hfd00, 16'h0400, 16'h0c00, 16'h0000});
    send_vector({16'h5555, 16'haaaa, 16'hffff, 16'h0000});
    send_vector({16'h0000, 16'h0000, 16'h0001, 16'h8000});
    random_vectors(30);

    foreach (dim_plan[p]) begin
      write_dimension(dim_plan[p]);
      steady <= ($urandom_range(0, 3) == 0);
      if (dim_plan[p] == 3'd4) send_vector({16'h0000, 16'h0000, 16'h0000, 16'h8000});
      random_vectors(42);
    end

    drain_all();
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== vector_normalize_fixed_unit.f =====
+incdir+rtl
rtl/vnf_pkg.sv
rtl/vnf_front.sv
rtl/vnf_lane.sv
rtl/vector_normalize_fixed_unit.sv
tb/sv/vnf_checker.sv
tb/sv/tb.sv
